@@ hdl/tcpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_pkg
// Shared types and constants of the tunnel packet deframer.
// ----------------------------------------------------------------------------
package tcpd_pkg;

    // Register map (index = byte address / 4)
    localparam int CFG_ADDR_BITS = 5;
    localparam logic [2:0] REG_END_NORMAL = 3'd0;
    localparam logic [2:0] REG_END_ERROR  = 3'd1;
    localparam logic [2:0] REG_FRAGMENT   = 3'd2;
    localparam logic [2:0] REG_TC_SEND    = 3'd3;
    localparam logic [2:0] REG_TC_GOT     = 3'd4;

    localparam logic [7:0] RST_END_NORMAL = 8'd0;
    localparam logic [7:0] RST_END_ERROR  = 8'd1;
    localparam logic [7:0] RST_FRAGMENT   = 8'd2;
    localparam logic [7:0] RST_TC_SEND    = 8'd48;
    localparam logic [7:0] RST_TC_GOT     = 8'd49;

    // Frame header
    localparam int         HEADER_BYTES = 12;
    localparam logic [3:0] HDR_LAST     = 4'(HEADER_BYTES - 1);
    localparam logic [3:0] HDR_LEN_FIRST = 4'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_FLAG = 2'd1;
    localparam logic [1:0] ERR_LENGTH   = 2'd2;

    typedef struct packed {
        logic [7:0] end_normal;
        logic [7:0] end_error;
        logic [7:0] fragment;
        logic [7:0] tc_send;
        logic [7:0] tc_got;
    } cfg_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] payload_byte;
        logic       packet_done;
        logic       end_kind;
        logic [1:0] error_code;
    } result_t;

endpackage

@@ hdl/tcp_tunnel_packet_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_tunnel_packet_deframer
// Deframes a length-prefixed tunnel byte stream into packet data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / stream_byte) takes one stream byte
//   per item. Output channel (out_valid / out_stall) delivers result items:
//   a data byte, a packet end with its kind, or an error code. Time-code
//   bytes and all header bytes but the last produce no item.
//   Throughput: one byte per cycle, sustained, while the output drains.
//   Each result is stored in the output register, or in the skid stage while
//   the receiver stalls; the parser state update is a single pass per byte.
//   When the receiver stalls, one result is held in the output register and
//   one more in the skid stage; in_stall rises only once both are full.
//   Reset clears the parser to the start of a header, empties the output
//   buffer and loads the default flag codes (0, 1, 2, 48, 49).
//   Flag codes are APB registers at byte addresses 0, 4, 8, 12, 16; write
//   them only while the block is idle.
// ----------------------------------------------------------------------------
module tcp_tunnel_packet_deframer #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcpd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          stream_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                has_byte,
    output logic [7:0]                          payload_byte,
    output logic                                packet_done,
    output logic                                end_kind,
    output logic [1:0]                          error_code
);
    import tcpd_pkg::*;

    cfg_t    cfg;
    logic    acc;
    logic    res_valid;
    result_t res;
    logic    buf_full;
    result_t out_data;

    assign in_stall = buf_full;
    assign acc      = in_valid && !buf_full;

    tcpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcpd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .acc         (acc),
        .stream_byte (stream_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    tcpd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (acc && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign has_byte     = out_data.has_byte;
    assign payload_byte = out_data.payload_byte;
    assign packet_done  = out_data.packet_done;
    assign end_kind     = out_data.end_kind;
    assign error_code   = out_data.error_code;

endmodule

@@ hdl/tcpd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_cfg
// Flag code registers behind an APB-style write/read port.
// ----------------------------------------------------------------------------
module tcpd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcpd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output tcpd_pkg::cfg_t                      cfg
);
    import tcpd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic [7:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_END_NORMAL: cfg_next.end_normal = pwdata[7:0];
                REG_END_ERROR:  cfg_next.end_error  = pwdata[7:0];
                REG_FRAGMENT:   cfg_next.fragment   = pwdata[7:0];
                REG_TC_SEND:    cfg_next.tc_send    = pwdata[7:0];
                REG_TC_GOT:     cfg_next.tc_got     = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_END_NORMAL: rd_val = cfg_reg.end_normal;
            REG_END_ERROR:  rd_val = cfg_reg.end_error;
            REG_FRAGMENT:   rd_val = cfg_reg.fragment;
            REG_TC_SEND:    rd_val = cfg_reg.tc_send;
            REG_TC_GOT:     rd_val = cfg_reg.tc_got;
            default:        rd_val = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_val};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.end_normal <= RST_END_NORMAL;
            cfg_reg.end_error  <= RST_END_ERROR;
            cfg_reg.fragment   <= RST_FRAGMENT;
            cfg_reg.tc_send    <= RST_TC_SEND;
            cfg_reg.tc_got     <= RST_TC_GOT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/tcpd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_core
// Frame parser: header, payload and time-code phases, one byte per cycle unless the input stalls.
// ----------------------------------------------------------------------------
module tcpd_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcpd_pkg::cfg_t      cfg,
    input  logic                acc,
    input  logic [7:0]          stream_byte,
    output logic                res_valid,
    output tcpd_pkg::result_t   res
);
    import tcpd_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CONTROL = 2'd2;

    logic [1:0]             phase_reg,     phase_next;
    logic [3:0]             hdr_idx_reg,   hdr_idx_next;
    logic [7:0]             flag_reg,      flag_next;
    logic [LENGTH_BITS-1:0] left_reg,      left_next;
    logic                   nonempty_reg,  nonempty_next;
    logic                   ovf_reg,       ovf_next;
    logic                   ctl_idx_reg,   ctl_idx_next;

    logic [7:0]             flag_w;
    logic [LENGTH_BITS-1:0] left_w;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [LENGTH_BITS+7:0] left_shift;
    logic                   ovf_w;
    logic                   final_w;
    logic                   normal_w;
    logic                   data_w;
    logic                   tc_w;
    logic                   in_header;

    assign left_dec   = left_reg - LENGTH_BITS'(1);
    assign left_shift = {left_reg, stream_byte};
    assign in_header  = (phase_reg != PH_PAYLOAD) && (phase_reg != PH_CONTROL);

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        flag_next     = flag_reg;
        left_next     = left_reg;
        nonempty_next = nonempty_reg;
        ovf_next      = ovf_reg;
        ctl_idx_next  = ctl_idx_reg;
        res_valid     = 1'b0;
        res           = '0;

        // header byte view of the frame fields; mid-frame, decode the stored flag
        flag_w = flag_reg;
        left_w = left_reg;
        ovf_w  = ovf_reg;
        if (in_header && hdr_idx_reg == 4'd0)
        begin
            flag_w = stream_byte;
            left_w = '0;
            ovf_w  = 1'b0;
        end
        else if (in_header && hdr_idx_reg >= HDR_LEN_FIRST)
        begin
            if (left_reg[LENGTH_BITS-1 -: 8] != 8'd0)
            begin
                ovf_w = 1'b1;
            end
            left_w = left_shift[LENGTH_BITS-1:0];
        end

        normal_w = (flag_w == cfg.end_normal);
        final_w  = normal_w || (flag_w == cfg.end_error);
        data_w   = final_w || (flag_w == cfg.fragment);
        tc_w     = (flag_w == cfg.tc_send) || (flag_w == cfg.tc_got);

        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                nonempty_next    = 1'b1;
                left_next        = left_dec;
                res_valid        = 1'b1;
                res.has_byte     = 1'b1;
                res.payload_byte = stream_byte;
                if (left_dec == '0)
                begin
                    phase_next = PH_HEADER;
                    if (final_w)
                    begin
                        res.packet_done = 1'b1;
                        res.end_kind    = !normal_w;
                        nonempty_next   = 1'b0;
                    end
                end
            end
            PH_CONTROL:
            begin
                ctl_idx_next = !ctl_idx_reg;
                if (ctl_idx_reg)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
                flag_next  = flag_w;
                left_next  = left_w;
                ovf_next   = ovf_w;
                if (hdr_idx_reg < HDR_LAST)
                begin
                    hdr_idx_next = hdr_idx_reg + 4'd1;
                end
                else
                begin
                    hdr_idx_next = 4'd0;
                    if (data_w)
                    begin
                        if (ovf_w)
                        begin
                            // drop the packet in progress, resync on next header
                            nonempty_next  = 1'b0;
                            left_next      = '0;
                            ovf_next       = 1'b0;
                            res_valid      = 1'b1;
                            res.error_code = ERR_LENGTH;
                        end
                        else if (left_w != '0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else if (final_w && nonempty_reg)
                        begin
                            nonempty_next   = 1'b0;
                            res_valid       = 1'b1;
                            res.packet_done = 1'b1;
                            res.end_kind    = !normal_w;
                        end
                    end
                    else
                    begin
                        left_next = '0;
                        ovf_next  = 1'b0;
                        if (tc_w)
                        begin
                            phase_next   = PH_CONTROL;
                            ctl_idx_next = 1'b0;
                        end
                        else
                        begin
                            nonempty_next  = 1'b0;
                            res_valid      = 1'b1;
                            res.error_code = ERR_BAD_FLAG;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_idx_reg  <= 4'd0;
            flag_reg     <= 8'd0;
            left_reg     <= '0;
            nonempty_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            ctl_idx_reg  <= 1'b0;
        end
        else if (acc)
        begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            flag_reg     <= flag_next;
            left_reg     <= left_next;
            nonempty_reg <= nonempty_next;
            ovf_reg      <= ovf_next;
            ctl_idx_reg  <= ctl_idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= HDR_LAST)
        else $error("header index past last header byte");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with no bytes left");

    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && phase_reg == PH_PAYLOAD) |-> (res_valid && res.has_byte))
        else $error("payload item produced no data byte");

    a_control_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && phase_reg == PH_CONTROL) |-> !res_valid)
        else $error("time-code byte produced a result");
`endif

endmodule

@@ hdl/tcpd_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpd_outbuf
// Result register with one skid stage between parser and output channel.
// ----------------------------------------------------------------------------
module tcpd_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcpd_pkg::result_t   push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output tcpd_pkg::result_t   out_data
);
    import tcpd_pkg::*;

    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;
    logic    take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take || !out_valid_reg)
        begin
            // output slot frees: refill from skid first to keep order
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item ahead of the output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("item pushed into a full buffer");
`endif

endmodule

@@ dv/tcp_tunnel_packet_deframer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_tunnel_packet_deframer_test
// Self-checking testbench for the tunnel packet deframer. Stream bytes are
// sent as well-formed frames, broken frames and noise. A behavioral parser
// in the bench predicts each data byte, packet end and error item, and a
// checker compares every output item against the oldest prediction.
// ----------------------------------------------------------------------------
module tcp_tunnel_packet_deframer_test;
    import tcpd_pkg::*;

    localparam int LENGTH_BITS   = 32;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEGMENT_BYTES = 76;

    typedef enum logic [1:0] {PARSE_HEADER, PARSE_PAYLOAD, PARSE_CONTROL} parse_phase_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               stream_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic                     has_byte;
    logic [7:0]               payload_byte;
    logic                     packet_done;
    logic                     end_kind;
    logic [1:0]               error_code;

    result_t dut_result;
    assign dut_result = {has_byte, payload_byte, packet_done, end_kind, error_code};

    // Behavioral parser state and flag codes
    parse_phase_t           parse_phase = PARSE_HEADER;
    logic [3:0]             hdr_pos     = '0;
    logic [7:0]             cur_flag    = '0;
    logic [LENGTH_BITS-1:0] remaining   = '0;
    logic                   pkt_open    = 1'b0;
    logic                   len_too_big = 1'b0;
    logic                   ctl_pos     = 1'b0;
    cfg_t                   codes = '{RST_END_NORMAL, RST_END_ERROR, RST_FRAGMENT,
                                      RST_TC_SEND, RST_TC_GOT};

    result_t expected_results[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int bytes_sent     = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    tcp_tunnel_packet_deframer #(.LENGTH_BITS(LENGTH_BITS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_byte     (has_byte),
        .payload_byte (payload_byte),
        .packet_done  (packet_done),
        .end_kind     (end_kind),
        .error_code   (error_code)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d items still expected", $time, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------------
    function automatic logic flag_is_final(input logic [7:0] f);
        return (f == codes.end_normal) || (f == codes.end_error);
    endfunction

    function automatic logic flag_is_data(input logic [7:0] f);
        return flag_is_final(f) || (f == codes.fragment);
    endfunction

    function automatic logic end_kind_of(input logic [7:0] f);
        return (f == codes.end_normal) ? 1'b0 : 1'b1;
    endfunction

    task automatic predict_deframe(input logic [7:0] b);
        result_t r;
        r = '0;
        case (parse_phase)
            PARSE_PAYLOAD:
            begin
                pkt_open       = 1'b1;
                remaining      = remaining - LENGTH_BITS'(1);
                r.has_byte     = 1'b1;
                r.payload_byte = b;
                if (remaining == 0)
                begin
                    parse_phase = PARSE_HEADER;
                    if (flag_is_final(cur_flag))
                    begin
                        r.packet_done = 1'b1;
                        r.end_kind    = end_kind_of(cur_flag);
                        pkt_open      = 1'b0;
                    end
                end
                expected_results.push_back(r);
            end
            PARSE_CONTROL:
            begin
                if (!ctl_pos)
                    ctl_pos = 1'b1;
                else
                begin
                    ctl_pos     = 1'b0;
                    parse_phase = PARSE_HEADER;
                end
            end
            default:
            begin
                parse_phase = PARSE_HEADER;
                if (hdr_pos == 0)
                begin
                    cur_flag    = b;
                    remaining   = '0;
                    len_too_big = 1'b0;
                end
                else if (hdr_pos >= HDR_LEN_FIRST)
                begin
                    if (remaining[LENGTH_BITS-1 -: 8] != 0)
                        len_too_big = 1'b1;
                    remaining = {remaining[LENGTH_BITS-9:0], b};
                end
                if (hdr_pos < HDR_LAST)
                    hdr_pos++;
                else
                begin
                    hdr_pos = '0;
                    if (flag_is_data(cur_flag))
                    begin
                        if (len_too_big)
                        begin
                            pkt_open     = 1'b0;
                            remaining    = '0;
                            len_too_big  = 1'b0;
                            r.error_code = ERR_LENGTH;
                            expected_results.push_back(r);
                        end
                        else if (remaining != 0)
                            parse_phase = PARSE_PAYLOAD;
                        else if (flag_is_final(cur_flag) && pkt_open)
                        begin
                            // empty final frame closes a packet that has data
                            pkt_open      = 1'b0;
                            r.packet_done = 1'b1;
                            r.end_kind    = end_kind_of(cur_flag);
                            expected_results.push_back(r);
                        end
                    end
                    else
                    begin
                        remaining   = '0;
                        len_too_big = 1'b0;
                        if (cur_flag == codes.tc_send || cur_flag == codes.tc_got)
                        begin
                            parse_phase = PARSE_CONTROL;
                            ctl_pos     = 1'b0;
                        end
                        else
                        begin
                            pkt_open     = 1'b0;
                            r.error_code = ERR_BAD_FLAG;
                            expected_results.push_back(r);
                        end
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $time, dut_result);
                error_count++;
            end
            else
            begin
                result_t want;
                want = expected_results.pop_front();
                check_field("has_byte", 8'(want.has_byte), 8'(dut_result.has_byte));
                check_field("payload_byte", want.payload_byte, dut_result.payload_byte);
                check_field("packet_done", 8'(want.packet_done), 8'(dut_result.packet_done));
                check_field("end_kind", 8'(want.end_kind), 8'(dut_result.end_kind));
                check_field("error_code", 8'(want.error_code), 8'(dut_result.error_code));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stream driving
    // ------------------------------------------------------------------------
    task automatic push_stream_byte(input logic [7:0] value);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= value;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        predict_deframe(value);
    endtask

    // Keep lengths of data frames short so that random bytes never park the
    // parser in a payload of millions of bytes.
    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (parse_phase == PARSE_HEADER && hdr_pos >= 8 && hdr_pos <= 10
            && flag_is_data(cur_flag))
            v = 8'h00;
        return v;
    endfunction

    task automatic finish_frame();
        while (!(parse_phase == PARSE_HEADER && hdr_pos == 0))
            push_stream_byte(noise_byte());
    endtask

    // Header with a 10-byte big-endian length, then whatever body it opens
    task automatic send_frame(input logic [7:0] flag, input logic [79:0] len80);
        push_stream_byte(flag);
        push_stream_byte(8'($urandom));
        for (int i = 9; i >= 0; i--)
            push_stream_byte(len80[i*8 +: 8]);
        while (parse_phase != PARSE_HEADER)
            push_stream_byte(8'($urandom));
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------------
    task automatic write_code_reg(input logic [2:0] idx, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_END_NORMAL: codes.end_normal = value;
            REG_END_ERROR:  codes.end_error  = value;
            REG_FRAGMENT:   codes.fragment   = value;
            REG_TC_SEND:    codes.tc_send    = value;
            default:        codes.tc_got     = value;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_code_reg(input logic [2:0] idx);
        logic [7:0] want;
        case (idx)
            REG_END_NORMAL: want = codes.end_normal;
            REG_END_ERROR:  want = codes.end_error;
            REG_FRAGMENT:   want = codes.fragment;
            REG_TC_SEND:    want = codes.tc_send;
            default:        want = codes.tc_got;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", want, prdata[7:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_all_codes(input logic [7:0] normal, input logic [7:0] err,
                                 input logic [7:0] frag, input logic [7:0] tc_s,
                                 input logic [7:0] tc_g);
        hold_until_drained();
        write_code_reg(REG_END_NORMAL, normal);
        write_code_reg(REG_END_ERROR, err);
        write_code_reg(REG_FRAGMENT, frag);
        write_code_reg(REG_TC_SEND, tc_s);
        write_code_reg(REG_TC_GOT, tc_g);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_code_registers();
        for (int i = 0; i < 5; i++)
            check_code_reg(3'(i));
        set_all_codes(8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01);
        for (int i = 0; i < 5; i++)
            check_code_reg(3'(i));
        set_all_codes(RST_END_NORMAL, RST_END_ERROR, RST_FRAGMENT, RST_TC_SEND, RST_TC_GOT);
    endtask

    task automatic test_directed_frames();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_frame(RST_FRAGMENT, 80'd1);
        send_frame(RST_FRAGMENT, 80'd0);
        send_frame(RST_END_NORMAL, 80'd2);       // last byte carries the end
        send_frame(RST_END_NORMAL, 80'd0);       // empty packet, drop silently
        send_frame(RST_FRAGMENT, 80'd3);
        send_frame(RST_END_ERROR, 80'd0);        // end with no byte
        send_frame(RST_TC_SEND, '1);             // length of a time code is ignored
        send_frame(RST_TC_GOT, 80'd0);
        send_frame(RST_FRAGMENT, 80'd2);
        send_frame(8'h77, 80'd0);                // unknown flag drops the packet
        send_frame(RST_END_NORMAL, 80'd0);
        send_frame(RST_FRAGMENT, 80'd1);
        send_frame(RST_END_ERROR, 80'h1_0000_0000); // just too long
        send_frame(RST_END_NORMAL, 80'd0);
        send_frame(RST_FRAGMENT, {8'hFF, 72'd5});
        send_frame(8'hFF, '1);
        hold_until_drained();
    endtask

    task automatic test_overlapping_codes();
        set_all_codes(8'h07, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(8'h07, 80'd2);                // normal end wins
        hold_until_drained();
        write_code_reg(REG_END_NORMAL, 8'h09);
        send_frame(8'h07, 80'd1);                // error end over fragment
        hold_until_drained();
        write_code_reg(REG_END_ERROR, 8'h0A);
        send_frame(8'h07, 80'd1);                // fragment over time codes
        send_frame(8'h09, 80'd0);
        hold_until_drained();
        write_code_reg(REG_FRAGMENT, 8'h0B);
        send_frame(8'h07, 80'd300);
        hold_until_drained();
        write_code_reg(REG_TC_SEND, 8'h0C);
        send_frame(8'h07, 80'd0);
        hold_until_drained();
        write_code_reg(REG_TC_GOT, 8'h0D);
        send_frame(8'h07, 80'd0);
        set_all_codes(RST_END_NORMAL, RST_END_ERROR, RST_FRAGMENT, RST_TC_SEND, RST_TC_GOT);
    endtask

    task automatic run_random_segment(input int n_bytes);
        int         start;
        int         sel;
        int         mode;
        logic [7:0] flag;
        logic [79:0] len80;
        logic [79:0] wide;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            sel  = $urandom_range(99);
            mode = 0;
            if (sel < 30)
                flag = codes.fragment;
            else if (sel < 50)
                flag = codes.end_normal;
            else if (sel < 60)
                flag = codes.end_error;
            else if (sel < 70)
            begin
                flag = codes.tc_send;
                mode = 2;
            end
            else if (sel < 77)
            begin
                flag = codes.tc_got;
                mode = 2;
            end
            else if (sel < 82)
            begin
                do
                    flag = 8'($urandom);
                while (flag_is_data(flag) || flag == codes.tc_send || flag == codes.tc_got);
                mode = 2;
            end
            else if (sel < 88)
            begin
                flag = ($urandom_range(1) == 0) ? codes.fragment : codes.end_normal;
                mode = 1;
            end
            else
                mode = 3;

            if (mode == 3)
            begin
                // broken frame: a run of stray bytes, then realign
                repeat ($urandom_range(1, 20)) push_stream_byte(noise_byte());
                finish_frame();
            end
            else
            begin
                wide  = 80'({$urandom, $urandom, $urandom});
                len80 = ($urandom_range(9) == 0) ? 80'($urandom_range(40))
                                                 : 80'($urandom_range(6));
                if (mode == 1)
                    len80 = len80 | (80'($urandom_range(1, 255)) << (8 * $urandom_range(4, 9)));
                else if (mode == 2 && !flag_is_data(flag))
                    len80 = wide;
                send_frame(flag, len80);
            end
        end
    endtask

    task automatic test_random_traffic();
        int idle_src[4]  = '{0, 87, 0, 16};
        int idle_sink[4] = '{0, 0, 87, 16};
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0: set_all_codes(RST_END_NORMAL, RST_END_ERROR, RST_FRAGMENT,
                                 RST_TC_SEND, RST_TC_GOT);
                1: set_all_codes(8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01);
                2: set_all_codes(8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                default: set_all_codes(8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC);
            endcase
            for (int p = 0; p < 4; p++)
            begin
                src_idle_pct   = idle_src[p];
                sink_stall_pct = idle_sink[p];
                run_random_segment(SEGMENT_BYTES);
                // pause the stream until every pending item is out
                hold_until_drained();
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        stream_byte = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_code_registers();
        test_directed_frames();
        test_overlapping_codes();
        test_random_traffic();
        hold_until_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ tcp_tunnel_packet_deframer.f @@
hdl/tcpd_pkg.sv
hdl/tcpd_cfg.sv
hdl/tcpd_core.sv
hdl/tcpd_outbuf.sv
hdl/tcp_tunnel_packet_deframer.sv
dv/tcp_tunnel_packet_deframer_test.sv
